[hdl/stl_pkg.sv]
// shared types and constants for the sorted table lower bound search
package stl_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16384;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W     = 32;

    // item kind codes
    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    // input transaction
    typedef struct packed {
        t_kind                       kind;
        logic                        start_new;
        logic signed [VALUE_W-1:0]   value;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [CNT_W-1:0] position;
        logic             not_found;
    } t_out;

    // search request from the top level
    typedef struct packed {
        logic                      start;
        logic signed [VALUE_W-1:0] key;
        logic [CNT_W-1:0]          count;
    } t_search_req;

    // search response to the top level
    typedef struct packed {
        logic done;
        t_out result;
    } t_search_rsp;

    // search sequencer states
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_EXP_RD  = 6'b000010,
        ST_EXP_CMP = 6'b000100,
        ST_NAR_RD  = 6'b001000,
        ST_NAR_CMP = 6'b010000,
        ST_DONE    = 6'b100000
    } t_state;

endpackage

[hdl/stl_ram.sv]
// generic simple dual port ram with registered read
module stl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/stl_search.sv]
// probe sequencer: exponential bracket then binary narrowing over the table ram
module stl_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stl_pkg::t_search_req          i_req,
    input  logic                          i_rsp_take,
    output stl_pkg::t_search_rsp          o_rsp,
    output logic                          o_busy,
    output logic [stl_pkg::ADDR_W-1:0]    o_rd_addr,
    input  logic signed [stl_pkg::VALUE_W-1:0] i_rd_data
);

    stl_pkg::t_state r_state, n_state;

    logic signed [stl_pkg::VALUE_W-1:0] r_key, n_key;
    logic [stl_pkg::CNT_W-1:0]  r_n, n_n;
    logic [stl_pkg::CNT_W-1:0]  r_lo1, n_lo1;
    logic [stl_pkg::ADDR_W-1:0] r_hi, n_hi;
    logic [stl_pkg::CNT_W-1:0]  r_span, n_span;
    logic [stl_pkg::CNT_W-1:0]  r_half, n_half;
    logic                       r_past, n_past;
    logic [stl_pkg::CNT_W-1:0]  r_pos, n_pos;
    logic                       r_nf, n_nf;

    logic [stl_pkg::CNT_W:0]    w_probe;
    logic [stl_pkg::CNT_W-1:0]  w_ceil;
    logic [stl_pkg::ADDR_W-1:0] w_rd_addr;
    logic                       w_key_gt;

    // shared compare unit: key above the element just read
    assign w_key_gt = r_key > i_rd_data;

    // next exponential probe position, 2 * (lo + 1)
    assign w_probe = {r_lo1, 1'b0};

    // larger half of the narrowing span, rounded up
    assign w_ceil = r_span - (r_span >> 1);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_n       = r_n;
        n_lo1     = r_lo1;
        n_hi      = r_hi;
        n_span    = r_span;
        n_half    = r_half;
        n_past    = r_past;
        n_pos     = r_pos;
        n_nf      = r_nf;
        w_rd_addr = r_hi;
        unique case (r_state)
            stl_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    n_key = i_req.key;
                    n_n   = i_req.count;
                    n_lo1 = '0;
                    if (i_req.count == '0) begin
                        n_pos   = '0;
                        n_nf    = 1'b1;
                        n_state = stl_pkg::ST_DONE;
                    end else begin
                        n_state = stl_pkg::ST_EXP_RD;
                    end
                end
            end
            stl_pkg::ST_EXP_RD: begin
                // a probe at or past the end reads the last element
                if (w_probe >= {1'b0, r_n}) begin
                    n_past = 1'b1;
                    n_hi   = stl_pkg::ADDR_W'(r_n - 1'b1);
                end else begin
                    n_past = 1'b0;
                    n_hi   = w_probe[stl_pkg::ADDR_W-1:0];
                end
                w_rd_addr = n_hi;
                n_state   = stl_pkg::ST_EXP_CMP;
            end
            stl_pkg::ST_EXP_CMP: begin
                if (!w_key_gt) begin
                    // bracket found, span runs from lo to hi
                    n_span  = stl_pkg::CNT_W'(r_hi) + 1'b1 - r_lo1;
                    n_state = stl_pkg::ST_NAR_RD;
                end else if (r_past) begin
                    n_pos   = r_n;
                    n_nf    = 1'b1;
                    n_state = stl_pkg::ST_DONE;
                end else begin
                    n_lo1   = stl_pkg::CNT_W'(r_hi) + 1'b1;
                    n_state = stl_pkg::ST_EXP_RD;
                end
            end
            stl_pkg::ST_NAR_RD: begin
                if (r_span <= stl_pkg::CNT_W'(1)) begin
                    n_pos   = stl_pkg::CNT_W'(r_hi);
                    n_nf    = 1'b0;
                    n_state = stl_pkg::ST_DONE;
                end else begin
                    n_half    = r_span >> 1;
                    w_rd_addr = r_hi - w_ceil[stl_pkg::ADDR_W-1:0];
                    n_state   = stl_pkg::ST_NAR_CMP;
                end
            end
            stl_pkg::ST_NAR_CMP: begin
                // span shrinks to its larger half either way
                n_span = r_span - r_half;
                if (!w_key_gt) begin
                    n_hi = r_hi - r_half[stl_pkg::ADDR_W-1:0];
                end
                n_state = stl_pkg::ST_NAR_RD;
            end
            stl_pkg::ST_DONE: begin
                if (i_rsp_take) begin
                    n_state = stl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stl_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_n    <= n_n;
        r_lo1  <= n_lo1;
        r_hi   <= n_hi;
        r_span <= n_span;
        r_half <= n_half;
        r_past <= n_past;
        r_pos  <= n_pos;
        r_nf   <= n_nf;
    end

    assign o_rd_addr              = w_rd_addr;
    assign o_busy                 = (r_state != stl_pkg::ST_IDLE);
    assign o_rsp.done             = (r_state == stl_pkg::ST_DONE);
    assign o_rsp.result.position  = r_pos;
    assign o_rsp.result.not_found = r_nf;

`ifndef SYNTH
    // a compare in the narrowing phase always has a span to split
    a_nar_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stl_pkg::ST_NAR_CMP) |-> (r_span > stl_pkg::CNT_W'(1)))
        else $error("narrowing compare with span below two");

    // every probe lands on a stored element
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == stl_pkg::ST_EXP_CMP) || (r_state == stl_pkg::ST_NAR_RD)
            || (r_state == stl_pkg::ST_NAR_CMP))
        |-> (stl_pkg::CNT_W'(r_hi) < r_n))
        else $error("probe position outside the stored elements");

    // a found position is below the element count
    a_found_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == stl_pkg::ST_DONE) && !r_nf) |-> (r_pos < r_n))
        else $error("found position not below the element count");
`endif

endmodule

[hdl/sorted_table_lower_bound.sv]
// Sorted table lower bound search. Load transactions append a signed 32-bit
// element to the table (start_new empties it first); loads beyond the table
// depth are dropped. A query transaction searches a table of up to 16384
// elements and returns the first index whose element is at least the key, or
// the element count with not_found set. The search probes positions 0, 2, 6,
// 14, ... and then halves the bracketed span; every probe is one read of the
// single table ram read port followed by a compare, and a closing span check,
// the result hand-over and the return to idle end the query. One query is in
// flight at a time and the input stalls while it runs; the result sits in an
// output register so a following load can be taken while the result waits to
// be collected.
module sorted_table_lower_bound (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  stl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output stl_pkg::t_out o_out_data
);

    logic [stl_pkg::CNT_W-1:0]  r_count, n_count;
    logic                       r_out_valid, n_out_valid;
    stl_pkg::t_out              r_out_data;

    logic                       w_in_take;
    logic                       w_wr_en;
    logic [stl_pkg::ADDR_W-1:0] w_wr_addr;
    logic [stl_pkg::ADDR_W-1:0] w_rd_addr;
    logic [stl_pkg::VALUE_W-1:0] w_rd_data;
    logic                       w_busy;
    logic                       w_rsp_take;
    stl_pkg::t_search_req       w_req;
    stl_pkg::t_search_rsp       w_rsp;

    // input transaction acceptance
    assign o_in_stall = w_busy;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // table load: start_new restarts at entry zero, a full table drops any other load
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[stl_pkg::ADDR_W-1:0];
        n_count   = r_count;
        if (w_in_take && (i_in_data.kind == stl_pkg::KIND_LOAD)) begin
            priority if (i_in_data.start_new) begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                n_count   = stl_pkg::CNT_W'(1);
            end else if (r_count < stl_pkg::CNT_W'(stl_pkg::TABLE_DEPTH)) begin
                w_wr_en = 1'b1;
                n_count = r_count + 1'b1;
            end else begin
                // full table, the load is dropped
                w_wr_en = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // query start
    assign w_req.start = w_in_take && (i_in_data.kind == stl_pkg::KIND_QUERY);
    assign w_req.key   = i_in_data.value;
    assign w_req.count = r_count;

    stl_ram #(
        .WIDTH (stl_pkg::VALUE_W),
        .DEPTH (stl_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in_data.value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    stl_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_rsp_take (w_rsp_take),
        .o_rsp      (w_rsp),
        .o_busy     (w_busy),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data)
    );

    // output register
    assign w_rsp_take = w_rsp.done && (!r_out_valid || !i_out_stall);

    always_comb begin
        priority if (w_rsp_take) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp_take) begin
            r_out_data <= w_rsp.result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    // an accepted query keeps the input stalled on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> w_busy)
        else $error("query accepted but search not running");

    // the element count never passes the table depth
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stl_pkg::CNT_W'(stl_pkg::TABLE_DEPTH))
        else $error("element count beyond table depth");

    // a restarting load leaves exactly one element
    a_restart_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && (i_in_data.kind == stl_pkg::KIND_LOAD) && i_in_data.start_new)
        |=> (r_count == stl_pkg::CNT_W'(1)))
        else $error("restarting load did not reset the count");
`endif

endmodule

[sim/tb.sv]
// self-checking testbench for the sorted table lower bound search
`timescale 1ns / 1ps

module tb;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          NUM_ROWS    = 22;
    localparam logic signed [stl_pkg::VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
    localparam logic signed [stl_pkg::VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;

    // one row of the directed table: transaction plus optional typed answer
    typedef struct packed {
        stl_pkg::t_in  item;
        logic          typed;
        stl_pkg::t_out answer;
    } t_row;

    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        // queries on the empty table after reset
        '{'{stl_pkg::KIND_QUERY, 1'b0, 32'sh0000_0000}, 1'b1, '{15'd0, 1'b1}},
        '{'{stl_pkg::KIND_QUERY, 1'b1, MAX_VALUE},      1'b1, '{15'd0, 1'b1}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, MIN_VALUE},      1'b1, '{15'd0, 1'b1}},
        // ascending table spanning both extremes, with a duplicate
        '{'{stl_pkg::KIND_LOAD,  1'b1, MIN_VALUE},      1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_LOAD,  1'b0, -32'sd5},        1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_LOAD,  1'b0, 32'sd0},         1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_LOAD,  1'b0, 32'sd7},         1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_LOAD,  1'b0, 32'sd7},         1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_LOAD,  1'b0, 32'sd100},       1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_LOAD,  1'b0, MAX_VALUE},      1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, MIN_VALUE},      1'b1, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, MAX_VALUE},      1'b1, '{15'd6, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, 32'sd7},         1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, 32'sd8},         1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, -32'sd6},        1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, 32'sd101},       1'b0, '{15'd0, 1'b0}},
        // start_new empties the table, single element
        '{'{stl_pkg::KIND_LOAD,  1'b1, 32'sd10},        1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, 32'sd11},        1'b1, '{15'd1, 1'b1}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, 32'sd10},        1'b1, '{15'd0, 1'b0}},
        // out-of-order append, answer follows the probe sequence
        '{'{stl_pkg::KIND_LOAD,  1'b0, 32'sd3},         1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, 32'sd4},         1'b0, '{15'd0, 1'b0}},
        '{'{stl_pkg::KIND_QUERY, 1'b0, -32'sd1},        1'b0, '{15'd0, 1'b0}}
    };

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_stall;
    stl_pkg::t_in  i_in_data   = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    stl_pkg::t_out o_out_data;

    // shadow copy of the table contents and fill level
    logic signed [stl_pkg::VALUE_W-1:0] shadow_table [stl_pkg::TABLE_DEPTH];
    int   shadow_count  = 0;

    stl_pkg::t_out pending_answers [$];
    stl_pkg::t_out head_answer;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   items_sent     = 0;
    int   idle_pct       = 0;
    int   stall_pct      = 0;
    bit   hold_request   = 1'b0;
    int   hold_left      = 0;
    longint fill_level;

    sorted_table_lower_bound u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table read, out-of-range indices read as zero
    function automatic logic signed [stl_pkg::VALUE_W-1:0] shadow_rd(longint idx);
        if (idx < 0 || idx >= stl_pkg::TABLE_DEPTH) return '0;
        return shadow_table[idx];
    endfunction

    // halve the bracket (lo, hi] down to the first element at least the key
    function automatic longint bisect_bracket(logic signed [stl_pkg::VALUE_W-1:0] key,
                                              longint lo, longint hi);
        longint span;
        longint half;
        span = hi - lo;
        while (span > 1) begin
            half = span / 2;
            if (key > shadow_rd(lo + half)) lo += half;
            else hi -= half;
            span = hi - lo;
        end
        return (shadow_rd(hi) >= key) ? hi : -1;
    endfunction

    // exponential probes at 0, 2, 6, 14, ... then bisection
    function automatic stl_pkg::t_out lower_bound_of(
        logic signed [stl_pkg::VALUE_W-1:0] key);
        longint        n;
        longint        lo;
        longint        hi;
        longint        found;
        stl_pkg::t_out res;
        n     = shadow_count;
        lo    = -1;
        hi    = 0;
        found = -1;
        while (found < 0 && hi < n) begin
            hi = (lo + 1) * 2;
            if (hi < n) begin
                if (shadow_rd(hi) >= key) found = bisect_bracket(key, lo, hi);
            end else if (shadow_rd(n - 1) >= key) begin
                found = bisect_bracket(key, lo, n - 1);
            end
            lo = hi;
        end
        if (found < 0) begin
            res.position  = shadow_count[stl_pkg::CNT_W-1:0];
            res.not_found = 1'b1;
        end else begin
            res.position  = found[stl_pkg::CNT_W-1:0];
            res.not_found = 1'b0;
        end
        return res;
    endfunction

    // offer one transaction, optional idle gap first, then track it once taken
    task automatic offer(input stl_pkg::t_in item, input logic typed,
                         input stl_pkg::t_out typed_res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 50) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (item.kind == stl_pkg::KIND_LOAD) begin
            if (item.start_new) shadow_count = 0;
            if (shadow_count < stl_pkg::TABLE_DEPTH) begin
                shadow_table[shadow_count] = item.value;
                shadow_count++;
            end
        end else if (typed) begin
            pending_answers.push_back(typed_res);
        end else begin
            pending_answers.push_back(lower_bound_of(item.value));
        end
    endtask

    task automatic load(input logic start,
                        input logic signed [stl_pkg::VALUE_W-1:0] value);
        stl_pkg::t_in item;
        item.kind      = stl_pkg::KIND_LOAD;
        item.start_new = start;
        item.value     = value;
        offer(item, 1'b0, '0);
    endtask

    task automatic ask(input logic signed [stl_pkg::VALUE_W-1:0] key);
        stl_pkg::t_in item;
        item.kind      = stl_pkg::KIND_QUERY;
        item.start_new = 1'($urandom_range(1));
        item.value     = key;
        offer(item, 1'b0, '0);
    endtask

    // drop valid and wait for every outstanding answer
    task automatic wait_for_answers();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // keys at the extremes, random keys, keys at stored elements and next to them
    function automatic logic signed [stl_pkg::VALUE_W-1:0] pick_key();
        logic signed [stl_pkg::VALUE_W-1:0] base;
        base = shadow_table[$urandom_range(shadow_count - 1)];
        case ($urandom_range(7))
            0: return MIN_VALUE;
            1: return MAX_VALUE;
            2: return $urandom();
            3, 4: return (base == MIN_VALUE) ? base : base - 1;
            5: return base;
            default: return (base == MAX_VALUE) ? base : base + 1;
        endcase
    endfunction

    // ascending table with random start, duplicates and wide steps
    task automatic build_sorted_table(input int n);
        longint level;
        case ($urandom_range(3))
            0: level = -64'sd2147483648;
            1: level = longint'($signed($urandom()));
            2: level = longint'($urandom_range(200)) - 100;
            default: level = -longint'($urandom_range(32'h7FFF_FFFF));
        endcase
        for (int i = 0; i < n; i++) begin
            load(i == 0, level[stl_pkg::VALUE_W-1:0]);
            case ($urandom_range(3))
                0: level += 0;
                1: level += $urandom_range(1, 3);
                2: level += $urandom_range(1, 1000);
                default: level += $urandom_range(32'h0FFF_FFFF);
            endcase
            if (level > 64'sd2147483647) level = 64'sd2147483647;
        end
    endtask

    // mostly sorted tables followed by queries, some raw noise
    task automatic run_random_phase(input int target);
        int           stop_at;
        int           pick;
        stl_pkg::t_in noise_item;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(3, 12)) begin
                    noise_item.kind      = stl_pkg::t_kind'($urandom_range(1));
                    noise_item.start_new = 1'($urandom_range(1));
                    noise_item.value     = $urandom();
                    offer(noise_item, 1'b0, '0);
                end
            end else begin
                pick = $urandom_range(99);
                if (pick < 60) build_sorted_table($urandom_range(1, 16));
                else if (pick < 90) build_sorted_table($urandom_range(17, 64));
                else build_sorted_table($urandom_range(65, 200));
                repeat ($urandom_range(6, 20)) ask(pick_key());
            end
        end
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checking against the oldest outstanding answer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d / %0b",
                         $time, o_out_data.position, o_out_data.not_found);
                mismatch_count++;
            end else begin
                head_answer = pending_answers.pop_front();
                if (o_out_data.position !== head_answer.position) begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, head_answer.position, o_out_data.position);
                    mismatch_count++;
                end
                if (o_out_data.not_found !== head_answer.not_found) begin
                    $display("%0t: not_found mismatch, expected %0b, actual %0b",
                             $time, head_answer.not_found, o_out_data.not_found);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int row = 0; row < NUM_ROWS; row++)
            offer(DIRECTED_ROWS[row].item, DIRECTED_ROWS[row].typed,
                  DIRECTED_ROWS[row].answer);

        // fill to capacity, then loads past the end are dropped
        for (int i = 0; i < stl_pkg::TABLE_DEPTH; i++) begin
            fill_level = -64'sd2147483648 + longint'(i) * 262144
                         + $urandom_range(262143);
            load(i == 0, fill_level[stl_pkg::VALUE_W-1:0]);
        end
        repeat (3) load(1'b0, MAX_VALUE);
        ask(MAX_VALUE);
        ask(MIN_VALUE);

        // long receiver hold-off while queries keep coming
        hold_request = 1'b1;
        repeat (20) ask(pick_key());

        // start_new on a full table still stores
        load(1'b1, $urandom());
        ask(MAX_VALUE);
        ask(MIN_VALUE);
        run_random_phase(250);
        wait_for_answers();

        // sender mostly idle, with a full pause half way
        idle_pct = 71;
        run_random_phase(125);
        wait_for_answers();
        run_random_phase(125);
        wait_for_answers();

        // receiver mostly stalling
        idle_pct  = 0;
        stall_pct = 71;
        run_random_phase(250);
        wait_for_answers();

        // both sides idling
        idle_pct  = 30;
        stall_pct = 30;
        run_random_phase(250);
        wait_for_answers();

        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
